@@ rtl/tspf_pkg.sv @@
`default_nettype none

package tspf_pkg;

  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned PROD_W = VAL_W + POS_W;
  localparam int unsigned REM_W = VAL_W + 1;
  localparam int unsigned STEP_W = 3;

  localparam logic [POS_W-1:0] RES_RESET = 8'd180;
  localparam logic [POS_W-1:0] OFFSET_RESET = 8'd24;
  localparam logic [POS_W-1:0] NO_POSITION = 8'hFF;
  localparam logic [3:0] PRELOAD_TICKS = 4'd4;
  localparam logic [3:0] HOLD_TICKS = 4'd3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

  typedef enum logic [0:0] {
    REG_RESOLUTION      = 1'b0,
    REG_POSITION_OFFSET = 1'b1
  } reg_index_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_PRE  = 9'b000010000,
    S_AVG  = 9'b000100000,
    S_CLMP = 9'b001000000,
    S_REL  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  function automatic logic [POS_W-1:0] sub_offset(input logic [POS_W-1:0] v,
                                                  input logic [POS_W-1:0] off);
    return (v >= off) ? (v - off) : '0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/touch_slider_position_filter.sv @@
`default_nettype none

// channel   | handshake                      | payload
// item      | item_valid / item_stall        | touched, reading_a/b, baseline_a/b
// position  | position_valid / position_stall| position
// config    | cfg_write                      | cfg_index, cfg_data
//
// Touched request: difference, multiply, then the 8-step restoring divider (one
// quotient bit per cycle), then preload or average and clamp, then output; both
// differences zero skip the divider. Released request: release, then output.
// item_stall is high from accept until the result is loaded into the output
// register; a held result does not block the next request.
// Synchronous reset restores state, config registers, counters and pointers.
module touch_slider_position_filter #(
  parameter int AVG_LOG2    = 4,
  parameter int DELAY_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [tspf_pkg::POS_W-1:0]  cfg_data,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        touched,
  input  wire logic [tspf_pkg::VAL_W-1:0]  reading_a,
  input  wire logic [tspf_pkg::VAL_W-1:0]  baseline_a,
  input  wire logic [tspf_pkg::VAL_W-1:0]  reading_b,
  input  wire logic [tspf_pkg::VAL_W-1:0]  baseline_b,
  output logic                             position_valid,
  input  wire logic                        position_stall,
  output logic [tspf_pkg::POS_W-1:0]       position
);

  localparam int WIN = 1 << AVG_LOG2;
  localparam int SUM_W = AVG_LOG2 + tspf_pkg::POS_W;
  localparam int DPW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int PW = tspf_pkg::POS_W;
  localparam int VW = tspf_pkg::VAL_W;

  tspf_pkg::state_t state, state_next;

  logic [PW-1:0]    resolution;
  logic [PW-1:0]    position_offset;
  logic [3:0]       touch_count;
  logic [3:0]       release_count;
  logic [AVG_LOG2-1:0] wptr;
  logic [DPW-1:0]   dptr;
  logic [WIN-1:0]   win_vld;

  logic [VW-1:0]    ra, ba, rb, bb;
  logic [VW-1:0]    da, db;
  logic [VW:0]      sum_r;
  logic [tspf_pkg::REM_W-1:0] rem;
  logic [PW-1:0]    quo;
  logic [tspf_pkg::STEP_W-1:0] step;
  logic [PW-1:0]    pre_val;
  logic [SUM_W-1:0] run_sum;
  logic             nopos;

  logic [PW-1:0]    win_mem [WIN];
  logic [PW-1:0]    win_rd;
  logic [PW-1:0]    dly [DELAY_DEPTH];

  logic             item_take;
  logic             out_free;
  logic             preload;
  logic [VW-1:0]    da_c, db_c;
  logic [VW:0]      sum_c;
  logic [tspf_pkg::PROD_W-1:0] prod;
  logic [tspf_pkg::REM_W:0]    trial;
  logic             trial_ge;
  logic [AVG_LOG2-1:0] wp1;
  logic [PW-1:0]    old_val;
  logic [PW-1:0]    avg;
  logic [PW-1:0]    clamped;
  logic [DPW-1:0]   dptr_inc;
  logic [3:0]       rc_inc;

  assign item_stall = (state != tspf_pkg::S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !position_valid || !position_stall;
  assign preload    = (touch_count < tspf_pkg::PRELOAD_TICKS);

  assign da_c  = (ra <= ba) ? (ba - ra) : '0;
  assign db_c  = (rb <= bb) ? (bb - rb) : '0;
  assign sum_c = {1'b0, da} + {1'b0, db};
  assign prod  = {{PW{1'b0}}, db} * {{VW{1'b0}}, resolution};

  assign trial    = {rem, quo[PW-1]};
  assign trial_ge = (trial >= {1'b0, sum_r});

  assign wp1     = wptr + AVG_LOG2'(1);
  assign old_val = win_vld[wp1] ? win_rd : pre_val;
  assign avg     = run_sum[SUM_W-1:AVG_LOG2];
  assign clamped = (avg > resolution) ? resolution : avg;
  assign dptr_inc = (dptr == DPW'(DELAY_DEPTH - 1)) ? '0 : dptr + DPW'(1);
  assign rc_inc   = release_count + 4'd1;

  always_comb begin
    state_next = state;
    case (state)
      tspf_pkg::S_IDLE: begin
        if (item_take) begin
          state_next = touched ? tspf_pkg::S_DIFF : tspf_pkg::S_REL;
        end
      end
      tspf_pkg::S_DIFF: state_next = tspf_pkg::S_MUL;
      tspf_pkg::S_MUL: begin
        if (sum_c == '0) begin
          state_next = preload ? tspf_pkg::S_PRE : tspf_pkg::S_AVG;
        end else begin
          state_next = tspf_pkg::S_DIV;
        end
      end
      tspf_pkg::S_DIV: begin
        if (step == tspf_pkg::LAST_STEP) begin
          state_next = preload ? tspf_pkg::S_PRE : tspf_pkg::S_AVG;
        end
      end
      tspf_pkg::S_PRE:  state_next = tspf_pkg::S_OUT;
      tspf_pkg::S_AVG:  state_next = tspf_pkg::S_CLMP;
      tspf_pkg::S_CLMP: state_next = tspf_pkg::S_OUT;
      tspf_pkg::S_REL:  state_next = tspf_pkg::S_OUT;
      tspf_pkg::S_OUT: begin
        if (out_free) begin
          state_next = tspf_pkg::S_IDLE;
        end
      end
      default: state_next = tspf_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tspf_pkg::S_IDLE;
      resolution      <= tspf_pkg::RES_RESET;
      position_offset <= tspf_pkg::OFFSET_RESET;
      touch_count     <= '0;
      release_count   <= '0;
      wptr            <= '0;
      dptr            <= '0;
      win_vld         <= '0;
      position_valid  <= 1'b0;
      step            <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          tspf_pkg::REG_RESOLUTION:      resolution <= cfg_data;
          tspf_pkg::REG_POSITION_OFFSET: position_offset <= cfg_data;
          default: ;
        endcase
      end
      if ((state == tspf_pkg::S_OUT) && out_free) begin
        position_valid <= 1'b1;
      end else if (!position_stall) begin
        position_valid <= 1'b0;
      end
      case (state)
        tspf_pkg::S_MUL: step <= '0;
        tspf_pkg::S_DIV: step <= step + tspf_pkg::STEP_W'(1);
        tspf_pkg::S_PRE: begin
          touch_count   <= touch_count + 4'd1;
          release_count <= '0;
          win_vld       <= '0;
          dptr          <= '0;
        end
        tspf_pkg::S_AVG: begin
          release_count <= '0;
          wptr          <= wp1;
          win_vld[wp1]  <= 1'b1;
        end
        tspf_pkg::S_CLMP: dptr <= dptr_inc;
        tspf_pkg::S_REL: begin
          if (!preload) begin
            release_count <= rc_inc;
            if (rc_inc > tspf_pkg::HOLD_TICKS) begin
              touch_count <= '0;
            end
          end else begin
            touch_count   <= '0;
            release_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    win_rd <= win_mem[wp1];
    if (item_take) begin
      ra <= reading_a;
      ba <= baseline_a;
      rb <= reading_b;
      bb <= baseline_b;
    end
    case (state)
      tspf_pkg::S_DIFF: begin
        da <= da_c;
        db <= db_c;
      end
      tspf_pkg::S_MUL: begin
        sum_r <= sum_c;
        rem   <= {1'b0, prod[tspf_pkg::PROD_W-1:PW]};
        quo   <= (sum_c == '0) ? '0 : prod[PW-1:0];
      end
      tspf_pkg::S_DIV: begin
        if (trial_ge) begin
          rem <= tspf_pkg::REM_W'(trial - {1'b0, sum_r});
        end else begin
          rem <= trial[tspf_pkg::REM_W-1:0];
        end
        quo <= {quo[PW-2:0], trial_ge};
      end
      tspf_pkg::S_PRE: begin
        pre_val <= quo;
        run_sum <= {quo, {AVG_LOG2{1'b0}}};
        for (int i = 0; i < DELAY_DEPTH; i++) begin
          dly[i] <= quo;
        end
        nopos <= 1'b1;
      end
      tspf_pkg::S_AVG: begin
        win_mem[wp1] <= quo;
        run_sum <= run_sum + SUM_W'(quo) - SUM_W'(old_val);
      end
      tspf_pkg::S_CLMP: begin
        dly[dptr] <= clamped;
        nopos     <= 1'b0;
      end
      tspf_pkg::S_REL: begin
        nopos <= preload || (rc_inc > tspf_pkg::HOLD_TICKS);
      end
      tspf_pkg::S_OUT: begin
        if (out_free) begin
          position <= nopos ? tspf_pkg::NO_POSITION
                            : tspf_pkg::sub_offset(dly[dptr], position_offset);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
